// ===== rtl/core/cspmv_pkg.sv =====
// Shared types and constants of the sparse matrix-vector accumulator.
`default_nettype none
package cspmv_pkg;
	localparam int SLICE_VOXELS = 4096;
	localparam int RAY_COUNT    = 1024;
	localparam int FRAC_BITS    = 16;
	localparam int DATA_W       = 32;
	localparam int PROD_W       = 2 * DATA_W;
	localparam int ROW_W        = 10;
	localparam int COL_W        = 12;
	localparam int VOX_AW       = (SLICE_VOXELS > 1) ? $clog2(SLICE_VOXELS) : 1;
	localparam int RAY_AW       = (RAY_COUNT > 1) ? $clog2(RAY_COUNT) : 1;

	typedef enum logic [1:0] {
		OP_LOAD_VOXEL = 2'd0,
		OP_LOAD_RAY   = 2'd1,
		OP_APPLY      = 2'd2,
		OP_READ_RAY   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                      operation;
		logic [ROW_W-1:0]         row_index;
		logic [COL_W-1:0]         column_index;
		logic signed [DATA_W-1:0] value;
		logic                     last_entry;
	} in_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]         ray_number;
		logic signed [DATA_W-1:0] ray_sum;
		logic                     done_res;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/core/cspmv_in_if.sv =====
// Input channel: valid/ready handshake carrying one command item.
`default_nettype none
interface cspmv_in_if;
	import cspmv_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cspmv_out_if.sv =====
// Output channel: valid/ready handshake carrying one ray report.
`default_nettype none
interface cspmv_out_if;
	import cspmv_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cspmv_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
`default_nettype none
module cspmv_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/cspmv_mac.sv =====
// Multiply stage and saturating accumulate of one matrix entry.
`default_nettype none
module cspmv_mac (
	input  wire logic                                clk,
	input  wire logic                                mul_en,
	input  wire logic signed [cspmv_pkg::DATA_W-1:0] weight,
	input  wire logic signed [cspmv_pkg::DATA_W-1:0] voxel,
	input  wire logic                                voxel_ok,
	input  wire logic signed [cspmv_pkg::DATA_W-1:0] ray_base,
	output logic signed      [cspmv_pkg::DATA_W-1:0] sum
);
	import cspmv_pkg::*;

	localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sh0000_0000_7FFF_FFFF);
	localparam logic signed [PROD_W-1:0] SAT_MIN = PROD_W'(-64'sh0000_0000_8000_0000);

	logic signed [DATA_W-1:0] voxel_sel;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [DATA_W-1:0] base_s1;
	logic signed [PROD_W-1:0] acc;

	// out-of-slice column reads as zero
	assign voxel_sel = voxel_ok ? voxel : '0;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= PROD_W'(weight) * PROD_W'(voxel_sel);
			base_s1 <= ray_base;
		end
	end

	// arithmetic shift rounds toward minus infinity
	always_comb begin
		acc = PROD_W'(base_s1) + (prod_s1 >>> FRAC_BITS);
		priority if (acc > SAT_MAX) begin
			sum = SAT_MAX[DATA_W-1:0];
		end else if (acc < SAT_MIN) begin
			sum = SAT_MIN[DATA_W-1:0];
		end else begin
			sum = acc[DATA_W-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/coo_sparse_matvec_accumulator.sv =====
// Top level: coordinate-format sparse matrix-vector accumulator with voxel and ray stores.
`default_nettype none
// Forward projector for one voxel slice. Each input transaction loads a voxel,
// loads an initial ray value, applies one matrix entry (ray[row] += weight *
// voxel[column], Q15.16, product floored and sum saturated to 32 bits) or
// reads a ray back. A read returns one report with done_res = 0; an entry
// flagged last_entry returns the updated ray with done_res = 1; loads and
// other entries return nothing. Out-of-range columns read as zero, and an
// entry to an out-of-range row changes nothing and reports a sum of zero.
// Sequencing: the block works on one transaction at a time; a load writes its
// store straight from the input. An entry passes through store read, multiply
// register, and add and write back; a last entry then moves its report into
// the output register. A read passes through store read, report capture and
// the move into the output register. That register frees the block while the
// report waits, but a second report stalls until the first is taken. Both
// stores are synchronous RAMs with registered reads, and the ray write back is
// done before the next transaction can read, so no forwarding is needed.
// Store contents are undefined until written; there is no clearing pass.
module coo_sparse_matvec_accumulator (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cspmv_in_if.sink    item,
	cspmv_out_if.source result
);
	import cspmv_pkg::*;

	state_t state_q;
	state_t state_d;

	logic accept;
	logic row_ok_in;
	logic col_ok_in;

	// held fields of the transaction in flight
	op_t                      op_q;
	logic [ROW_W-1:0]         row_q;
	logic signed [DATA_W-1:0] weight_q;
	logic                     row_ok_q;
	logic                     col_ok_q;
	logic                     last_q;

	// store ports
	logic                     vox_wr_en;
	logic                     vox_rd_en;
	logic [DATA_W-1:0]        vox_rd_data;
	logic                     ray_wr_en;
	logic [RAY_AW-1:0]        ray_wr_addr;
	logic [DATA_W-1:0]        ray_wr_data;
	logic                     ray_rd_en;
	logic [DATA_W-1:0]        ray_rd_data;

	logic                     mul_en;
	logic signed [DATA_W-1:0] mac_sum;

	// report waiting for the output register, and the output register
	out_item_t                res_q;
	out_item_t                out_data_q;
	logic                     out_valid_q;
	logic                     out_load;

	assign accept    = item.valid && item.ready;
	assign row_ok_in = int'(item.data.row_index) < RAY_COUNT;
	assign col_ok_in = int'(item.data.column_index) < SLICE_VOXELS;

	cspmv_ram #(
		.DEPTH(SLICE_VOXELS),
		.WIDTH(DATA_W)
	) u_voxel_store (
		.clk    (clk),
		.wr_en  (vox_wr_en),
		.wr_addr(VOX_AW'(item.data.column_index)),
		.wr_data(item.data.value),
		.rd_en  (vox_rd_en),
		.rd_addr(VOX_AW'(item.data.column_index)),
		.rd_data(vox_rd_data)
	);

	cspmv_ram #(
		.DEPTH(RAY_COUNT),
		.WIDTH(DATA_W)
	) u_ray_store (
		.clk    (clk),
		.wr_en  (ray_wr_en),
		.wr_addr(ray_wr_addr),
		.wr_data(ray_wr_data),
		.rd_en  (ray_rd_en),
		.rd_addr(RAY_AW'(item.data.row_index)),
		.rd_data(ray_rd_data)
	);

	cspmv_mac u_mac (
		.clk     (clk),
		.mul_en  (mul_en),
		.weight  (weight_q),
		.voxel   (vox_rd_data),
		.voxel_ok(col_ok_q),
		.ray_base(ray_rd_data),
		.sum     (mac_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control. Loads write straight from the input; entries and
	// reads issue their store reads at the accepting edge.
	always_comb begin
		state_d     = state_q;
		item.ready  = 1'b0;
		vox_wr_en   = 1'b0;
		vox_rd_en   = 1'b0;
		ray_wr_en   = 1'b0;
		ray_wr_addr = RAY_AW'(item.data.row_index);
		ray_wr_data = item.data.value;
		ray_rd_en   = 1'b0;
		mul_en      = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					unique case (item.data.operation)
						OP_LOAD_VOXEL: begin
							vox_wr_en = col_ok_in;
						end
						OP_LOAD_RAY: begin
							ray_wr_en = row_ok_in;
						end
						OP_APPLY: begin
							vox_rd_en = 1'b1;
							ray_rd_en = 1'b1;
							state_d   = ST_MUL;
						end
						OP_READ_RAY: begin
							ray_rd_en = 1'b1;
							state_d   = ST_MUL;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_MUL: begin
				// read data is here: a read reports it, an entry multiplies
				mul_en  = (op_q == OP_APPLY);
				state_d = (op_q == OP_APPLY) ? ST_ACC : ST_OUT;
			end
			ST_ACC: begin
				// write back the saturated sum; drop out-of-range rows
				ray_wr_en   = row_ok_q;
				ray_wr_addr = RAY_AW'(row_q);
				ray_wr_data = mac_sum;
				state_d     = last_q ? ST_OUT : ST_IDLE;
			end
			ST_OUT: begin
				// hold until the output register is free or being emptied
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= item.data.operation;
			row_q    <= item.data.row_index;
			weight_q <= item.data.value;
			row_ok_q <= row_ok_in;
			col_ok_q <= col_ok_in;
			last_q   <= item.data.last_entry;
		end
	end

	// Build the pending report.
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL && op_q == OP_READ_RAY) begin
			res_q.ray_number <= row_q;
			res_q.ray_sum    <= row_ok_q ? ray_rd_data : '0;
			res_q.done_res   <= 1'b0;
		end else if (state_q == ST_ACC) begin
			res_q.ray_number <= row_q;
			res_q.ray_sum    <= row_ok_q ? mac_sum : '0;
			res_q.done_res   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;
endmodule
`default_nettype wire
